>>> src/osp_pkg.sv
// ----------------------------------------------------------------------------
// osp_pkg: shared types and constants of the one-shot phase ramp
// Beat formats of the item and result channels, register indices and the
// fixed-point widths that the payload fields settle.
// ----------------------------------------------------------------------------
package osp_pkg;

  localparam int unsigned FracBits  = 32;
  localparam int unsigned PhaseW    = FracBits + 1;
  localparam int unsigned RawW      = FracBits + 8;
  localparam int unsigned FreqW     = 32;
  localparam int unsigned ScaleW    = 40;
  localparam int unsigned ScaleLoW  = ScaleW / 2;
  localparam int unsigned ScaleHiW  = ScaleW - ScaleLoW;
  localparam int unsigned PartW     = FreqW + ScaleLoW;
  localparam int unsigned ProdW     = FreqW + ScaleW;
  localparam int unsigned IncShift  = 64 - FracBits;
  localparam int unsigned QuotW     = ProdW - IncShift;
  localparam int unsigned IncW      = QuotW + 1;
  localparam int unsigned SumW      = IncW + 1;
  localparam int unsigned CfgIdxW   = 4;

  localparam logic [CfgIdxW-1:0] RegConvScale = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegLoopMode  = CfgIdxW'(1);

  localparam logic [PhaseW-1:0] PhaseOne = {1'b1, {FracBits{1'b0}}};

  typedef struct packed {
    logic                    kind;
    logic signed [FreqW-1:0] frequency;
    logic [PhaseW-1:0]       new_phase;
  } osp_in_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase_out;
    logic              hit_high;
    logic              hit_low;
  } osp_out_t;

endpackage

>>> src/one_shot_phase_ramp.sv
// ----------------------------------------------------------------------------
// one_shot_phase_ramp: phase ramp with one-shot clamping and loop wrapping
// Three-stage pipeline: two partial products of frequency and scale, the
// floored increment, then the phase update with zone events and clamping.
// ----------------------------------------------------------------------------
// Usage
//   Items arrive on the in channel (valid/ready). An advance item yields one
//   result beat on the out channel; a load item sets the phase and yields
//   none. Registers are written on the cfg channel, which is always ready;
//   write them only while no item is in flight.
//   An item passes stage 1 and stage 2 before its result is loaded into
//   the output register. Throughput is one item per cycle unless the
//   receiver stalls, set by the single add-and-saturate loop on raw_q.
//   The input side keeps accepting while a result waits, as long as a
//   pipeline stage is free; when the receiver stalls, both stages hold an
//   item and the stage 2 item is an advance, in_ready_o falls until the
//   output beat is taken. Reset clears the pipeline, both registers, the
//   raw phase (to zero) and the zone (to low).
// ----------------------------------------------------------------------------
module one_shot_phase_ramp
  import osp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  osp_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output osp_out_t            out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [ScaleW-1:0]   cfg_data_i
);

  localparam logic [1:0] ZoneLow  = 2'd0;
  localparam logic [1:0] ZoneHigh = 2'd1;
  localparam logic [1:0] ZoneMid  = 2'd2;

  logic [ScaleW-1:0]      conv_scale_q;
  logic                   loop_mode_q;

  logic                   s1_valid_q, s1_kind_q, s1_neg_q;
  logic [PhaseW-1:0]      s1_phase_q;
  logic [PartW-ScaleLoW+ScaleHiW-1:0] s1_pa_q;
  logic [PartW-1:0]       s1_pb_q;

  logic                   s2_valid_q, s2_kind_q;
  logic [PhaseW-1:0]      s2_phase_q;
  logic signed [IncW-1:0] s2_inc_q, s2_inc_d;

  logic signed [RawW-1:0] raw_q, raw_d;
  logic [1:0]             zone_q, zone_d;
  logic                   out_valid_q;
  osp_out_t               out_q, out_d;

  logic                   out_en, s2_go, s2_free, s1_go, s1_free, in_fire;
  logic [FreqW-1:0]       freq_bits, freq_mag;
  logic [ProdW-1:0]       prod;
  logic [QuotW-1:0]       quot;
  logic                   rem_nz;
  logic                   at_high, at_low;
  logic [PhaseW-1:0]      cur, load_phase;
  logic signed [SumW-1:0] sum;

  assign out_en     = !out_valid_q || out_ready_i;
  assign s2_go      = s2_valid_q && (s2_kind_q || out_en);
  assign s2_free    = !s2_valid_q || s2_go;
  assign s1_go      = s1_valid_q && s2_free;
  assign s1_free    = !s1_valid_q || s1_go;
  assign in_fire    = in_valid_i && s1_free;

  assign in_ready_o  = s1_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  assign freq_bits = in_data_i.frequency;
  assign freq_mag  = freq_bits[FreqW-1] ? (~freq_bits + FreqW'(1)) : freq_bits;

  always_comb begin
    prod     = {s1_pa_q, {ScaleLoW{1'b0}}} + {{ScaleHiW{1'b0}}, s1_pb_q};
    quot     = prod[ProdW-1:IncShift];
    rem_nz   = |prod[IncShift-1:0];
    if (s1_neg_q) begin
      s2_inc_d = $signed(~{1'b0, quot}) + $signed({{QuotW{1'b0}}, !rem_nz});
    end else begin
      s2_inc_d = $signed({1'b0, quot});
    end
  end

  always_comb begin
    at_high    = !raw_q[RawW-1] && (|raw_q[RawW-2:FracBits]);
    at_low     = raw_q[RawW-1] || (raw_q == '0);
    load_phase = (s2_phase_q >= PhaseOne) ? PhaseOne : s2_phase_q;
    out_d      = '0;
    zone_d     = zone_q;
    raw_d      = raw_q;
    cur        = raw_q[PhaseW-1:0];
    if (at_high) begin
      cur    = PhaseOne;
      zone_d = ZoneHigh;
      out_d.hit_high = (zone_q != ZoneHigh);
    end else if (at_low) begin
      cur    = '0;
      zone_d = ZoneLow;
      out_d.hit_low = (zone_q != ZoneLow);
    end else begin
      zone_d = ZoneMid;
    end
    if (loop_mode_q) begin
      cur[FracBits] = 1'b0;
    end
    out_d.phase_out = cur;
    sum = $signed({{(SumW-PhaseW){1'b0}}, cur}) + SumW'(s2_inc_q);
    if (sum[SumW-1:RawW-1] == '0 || sum[SumW-1:RawW-1] == '1) begin
      raw_d = sum[RawW-1:0];
    end else if (sum[SumW-1]) begin
      raw_d = {1'b1, {(RawW-1){1'b0}}};
    end else begin
      raw_d = {1'b0, {(RawW-1){1'b1}}};
    end
    if (s2_kind_q) begin
      raw_d = $signed({{(RawW-PhaseW){1'b0}}, load_phase});
      if (load_phase == PhaseOne) begin
        zone_d = ZoneHigh;
      end else if (load_phase == '0) begin
        zone_d = ZoneLow;
      end else begin
        zone_d = zone_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_scale_q <= '0;
      loop_mode_q  <= 1'b0;
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      raw_q        <= '0;
      zone_q       <= ZoneLow;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegConvScale: conv_scale_q <= cfg_data_i;
          RegLoopMode:  loop_mode_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (s1_free) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_en) begin
        out_valid_q <= s2_valid_q && !s2_kind_q;
      end
      if (s2_go) begin
        raw_q  <= raw_d;
        zone_q <= zone_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q  <= in_data_i.kind;
      s1_neg_q   <= freq_bits[FreqW-1];
      s1_phase_q <= in_data_i.new_phase;
      s1_pa_q    <= freq_mag * conv_scale_q[ScaleW-1:ScaleLoW];
      s1_pb_q    <= freq_mag * conv_scale_q[ScaleLoW-1:0];
    end
    if (s1_go) begin
      s2_kind_q  <= s1_kind_q;
      s2_phase_q <= s1_phase_q;
      s2_inc_q   <= s2_inc_d;
    end
    if (s2_go && !s2_kind_q) begin
      out_q <= out_d;
    end
  end

endmodule

>>> src/osp_checker.sv
// ----------------------------------------------------------------------------
// osp_assert: port-level checks for the one-shot phase ramp
// Watches the result channel for stalled-beat stability and for phase and
// event combinations that the ramp can never produce.
// ----------------------------------------------------------------------------
module osp_assert
  import osp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                out_valid_o,
  input  logic                out_ready_i,
  input  osp_out_t            out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("Stalled result beat changed or was dropped.");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.phase_out[FracBits] |->
      out_data_o.phase_out[FracBits-1:0] == '0)
    else $error("Result phase exceeds one.");

  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.hit_high && out_data_o.hit_low))
    else $error("Both zone events raised in one beat.");

  a_high_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hit_high |->
      out_data_o.phase_out[FracBits-1:0] == '0)
    else $error("High event with a phase other than one or its wrap.");

  a_low_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hit_low |-> out_data_o.phase_out == '0)
    else $error("Low event with a non-zero phase.");

endmodule

bind one_shot_phase_ramp osp_assert u_osp_assert (.*);

>>> bench/osp_tb_pkg.sv
// ----------------------------------------------------------------------------
// osp_tb_pkg: item codes shared by the phase ramp testbench
// Item kinds and a register index outside the register map, used by both the
// stimulus and the checker.
// ----------------------------------------------------------------------------
package osp_tb_pkg;
  import osp_pkg::*;

  localparam logic KindAdvance = 1'b0;
  localparam logic KindLoad    = 1'b1;

  localparam logic [CfgIdxW-1:0] RegSpare = CfgIdxW'(15);

endpackage

>>> bench/osp_checker.sv
// ----------------------------------------------------------------------------
// osp_checker: result checker for the one-shot phase ramp
// Watches the item, result and register channels, keeps its own copy of the
// raw phase, zone and registers, predicts each result beat and compares it
// with the beat the block delivers. Hands on a failure count and the number
// of results still awaited.
// ----------------------------------------------------------------------------
module osp_checker
  import osp_pkg::*;
  import osp_tb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  osp_in_t            in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  osp_out_t           out_data_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ScaleW-1:0]  cfg_data_i,
  output int unsigned        pending_o,
  output int unsigned        errors_o
);

  typedef enum logic [1:0] {
    ZoneLow  = 2'd0,
    ZoneHigh = 2'd1,
    ZoneMid  = 2'd2
  } zone_e;

  localparam int unsigned WideW = ProdW + 2;

  localparam logic signed [RawW-1:0] RawTop    = {1'b0, {(RawW-1){1'b1}}};
  localparam logic signed [RawW-1:0] RawBottom = {1'b1, {(RawW-1){1'b0}}};

  logic signed [RawW-1:0] raw_q;
  zone_e                  zone_q;
  logic [ScaleW-1:0]      scale_q;
  logic                   wrap_q;
  osp_out_t               awaited_q[$];
  int unsigned            errors;

  function automatic osp_out_t ramp_advance(input logic signed [FreqW-1:0] freq);
    osp_out_t               res;
    logic signed [WideW-1:0] cur, one_w, top_w, bottom_w, f_w, s_w, inc, nxt;
    res      = '0;
    one_w    = $signed({1'b0, PhaseOne});
    top_w    = RawTop;
    bottom_w = RawBottom;
    cur      = raw_q;
    if (cur >= one_w) begin
      cur          = one_w;
      res.hit_high = (zone_q != ZoneHigh);
      zone_q       = ZoneHigh;
    end else if (cur <= 0) begin
      cur         = '0;
      res.hit_low = (zone_q != ZoneLow);
      zone_q      = ZoneLow;
    end else begin
      zone_q = ZoneMid;
    end
    if (wrap_q) begin
      cur = cur & (one_w - 1);
    end
    res.phase_out = cur[PhaseW-1:0];
    f_w = freq;
    s_w = $signed({1'b0, scale_q});
    inc = (f_w * s_w) >>> IncShift;
    nxt = cur + inc;
    if (nxt > top_w) begin
      nxt = top_w;
    end else if (nxt < bottom_w) begin
      nxt = bottom_w;
    end
    raw_q = nxt[RawW-1:0];
    return res;
  endfunction

  function automatic void phase_load(input logic [PhaseW-1:0] np);
    logic [PhaseW-1:0] v;
    v     = (np >= PhaseOne) ? PhaseOne : np;
    raw_q = $signed({{(RawW-PhaseW){1'b0}}, v});
    if (v == PhaseOne) begin
      zone_q = ZoneHigh;
    end else if (v == '0) begin
      zone_q = ZoneLow;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    osp_out_t want;
    if (!rst_ni) begin
      raw_q   = '0;
      zone_q  = ZoneLow;
      scale_q = '0;
      wrap_q  = 1'b0;
      awaited_q.delete();
      errors  = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_q.size() == 0) begin
          errors++;
          $display("%0t: result beat with none expected: phase %h high %b low %b",
                   $time, out_data_i.phase_out, out_data_i.hit_high, out_data_i.hit_low);
        end else begin
          want = awaited_q.pop_front();
          if (out_data_i.phase_out != want.phase_out ||
              out_data_i.hit_high != want.hit_high ||
              out_data_i.hit_low != want.hit_low) begin
            errors++;
            $display("%0t: mismatch, expected phase %h high %b low %b, got phase %h high %b low %b",
                     $time, want.phase_out, want.hit_high, want.hit_low,
                     out_data_i.phase_out, out_data_i.hit_high, out_data_i.hit_low);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegConvScale: begin
            scale_q = cfg_data_i;
          end
          RegLoopMode: begin
            wrap_q = cfg_data_i[0];
          end
          default: begin
          end
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.kind == KindLoad) begin
          phase_load(in_data_i.new_phase);
        end else begin
          awaited_q.push_back(ramp_advance(in_data_i.frequency));
        end
      end
    end
    pending_o <= awaited_q.size();
    errors_o  <= errors;
  end

endmodule

>>> bench/one_shot_phase_ramp_tb.sv
// ----------------------------------------------------------------------------
// one_shot_phase_ramp_tb: testbench top for the one-shot phase ramp
// Drives a short directed sequence over the phase bounds, events, loads and
// register extremes, then phases of random ramps, loads and noise under
// several register settings and idling patterns. A separate checker predicts
// and compares every result beat; this module gives the verdict.
// ----------------------------------------------------------------------------
module one_shot_phase_ramp_tb;
  import osp_pkg::*;
  import osp_tb_pkg::*;

  localparam int unsigned ResetCycles = 8;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned HoldAt      = 50;
  localparam int unsigned PhaseCount  = 6;
  localparam int unsigned PhaseItems  = 200;

  localparam logic [ScaleW-1:0] ScaleAudio = 40'd5864062014;
  localparam logic [ScaleW-1:0] ScaleMax   = {ScaleW{1'b1}};

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  osp_in_t            in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  osp_out_t           out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [ScaleW-1:0]  cfg_data = '0;

  int unsigned        pending;
  int unsigned        errors;
  int unsigned        send_pct = 0;
  int unsigned        recv_pct = 0;
  int unsigned        hold_asks = 0;
  logic [ScaleW-1:0]  scale_now = '0;

  one_shot_phase_ramp DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  osp_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("one_shot_phase_ramp_tb: done, errors");
    $finish;
  end

  // The receiver counts a requested hold-off itself.
  initial begin
    int unsigned hold_left;
    int unsigned holds_seen;
    hold_left  = 0;
    holds_seen = 0;
    forever begin
      @(posedge clk_i);
      if (holds_seen != hold_asks) begin
        holds_seen = hold_asks;
        hold_left  = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_pct);
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ScaleW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
    if (idx == RegConvScale) begin
      scale_now = value;
    end
  endtask

  task automatic send_beat(input osp_in_t beat);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // The count of awaited results is registered, so it settles only after the last beat.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic osp_in_t advance_beat(input logic [FreqW-1:0] freq);
    osp_in_t beat;
    beat.kind      = KindAdvance;
    beat.frequency = freq;
    beat.new_phase = {1'($urandom_range(1)), $urandom()};
    return beat;
  endfunction

  function automatic osp_in_t load_beat(input logic [PhaseW-1:0] ph);
    osp_in_t beat;
    beat.kind      = KindLoad;
    beat.frequency = $urandom();
    beat.new_phase = ph;
    return beat;
  endfunction

  function automatic logic [PhaseW-1:0] pick_phase();
    logic [PhaseW-1:0] ph;
    case ($urandom_range(3))
      0: ph = '0;
      1: ph = PhaseOne;
      2: ph = {1'b0, $urandom()};
      default: ph = {1'b1, $urandom()};
    endcase
    return ph;
  endfunction

  // Frequency magnitude that crosses the whole phase range in about the
  // given number of samples at the current scale (random below 65536).
  function automatic int unsigned ramp_mag(input int unsigned steps);
    longint unsigned m;
    if (scale_now < 65536) begin
      return $urandom_range(1 << 20, 1);
    end
    m = (((64'h1 << 63) / steps) / scale_now) << 1;
    if (m > 64'h7FFF_FFFF) begin
      m = 64'h7FFF_FFFF;
    end
    if (m == 0) begin
      m = 1;
    end
    return int'(m);
  endfunction

  task automatic random_phase(input int unsigned count);
    int unsigned       n;
    int unsigned       pick;
    int unsigned       burst;
    int unsigned       mag;
    int unsigned       jmag;
    bit                neg;
    logic [FreqW-1:0]  freq;
    osp_in_t           beat;
    burst = 0;
    pick  = 0;
    mag   = 1;
    neg   = 1'b0;
    for (n = 0; n < count; n++) begin
      if (burst == 0) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          burst = $urandom_range(40, 5);
          mag   = ramp_mag($urandom_range(60, 2));
          neg   = ($urandom_range(3) == 0);
        end
      end
      if (burst != 0) begin
        burst--;
        jmag = mag - mag / 8 + $urandom_range(mag / 4);
        freq = FreqW'(jmag);
        if (neg) begin
          freq = -freq;
        end
        beat = advance_beat(freq);
      end else if (pick < 82) begin
        beat = load_beat(pick_phase());
      end else if (pick < 95) begin
        beat = advance_beat($urandom());
      end else begin
        case ($urandom_range(3))
          0: freq = 32'h7FFF_FFFF;
          1: freq = 32'h8000_0000;
          2: freq = '0;
          default: freq = 32'hFFFF_FFFF;
        endcase
        beat = advance_beat(freq);
      end
      if (n == HoldAt) begin
        hold_asks++;
      end
      send_beat(beat);
    end
  endtask

  initial begin
    int unsigned ph;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(advance_beat(32'd440 << 16));
    drain_results();
    write_reg(RegConvScale, ScaleAudio);
    write_reg(RegLoopMode, 40'd0);
    write_reg(RegSpare, {8'($urandom()), $urandom()});
    send_beat(advance_beat(32'd440 << 16));
    send_beat(advance_beat(32'h7FFF_FFFF));
    send_beat(advance_beat('0));
    send_beat(advance_beat(32'h8000_0000));
    send_beat(advance_beat(32'h8000_0000));
    send_beat(advance_beat('0));
    send_beat(load_beat(PhaseOne));
    send_beat(advance_beat('0));
    send_beat(load_beat({PhaseW{1'b1}}));
    send_beat(advance_beat(32'hFFFF_FFFF));
    send_beat(advance_beat('0));
    send_beat(load_beat('0));
    send_beat(advance_beat(32'd1));
    send_beat(load_beat(33'h0_8000_0000));
    send_beat(advance_beat('0));
    drain_results();
    write_reg(RegConvScale, ScaleMax);
    write_reg(RegLoopMode, 40'd1);
    send_beat(advance_beat(32'h7FFF_FFFF));
    send_beat(advance_beat(32'h8000_0000));
    send_beat(advance_beat(32'h8000_0000));
    send_beat(load_beat(PhaseOne));
    send_beat(advance_beat('0));
    send_beat(load_beat(33'h0_4000_0000));
    send_beat(advance_beat('0));

    for (ph = 0; ph < PhaseCount; ph++) begin
      drain_results();
      if (ph < 2) begin
        send_pct = 16;
        recv_pct = 63;
      end else if (ph < 4) begin
        send_pct = 63;
        recv_pct = 16;
      end else begin
        send_pct = 0;
        recv_pct = 0;
      end
      case (ph)
        0: begin
          write_reg(RegConvScale, ScaleAudio);
          write_reg(RegLoopMode, 40'd0);
        end
        1: begin
          write_reg(RegConvScale, {8'($urandom()), $urandom()});
          write_reg(RegLoopMode, 40'd1);
        end
        2: begin
          write_reg(RegConvScale, '0);
          write_reg(RegLoopMode, 40'd0);
        end
        3: begin
          write_reg(RegConvScale, ScaleAudio);
          write_reg(RegLoopMode, 40'd1);
        end
        4: begin
          write_reg(RegConvScale, ScaleMax);
          write_reg(RegLoopMode, 40'd1);
        end
        default: begin
          write_reg(RegConvScale, {6'd0, 2'($urandom_range(3)), $urandom()});
          write_reg(RegLoopMode, 40'd0);
        end
      endcase
      random_phase(PhaseItems);
    end
    drain_results();

    if (errors == 0) begin
      $display("one_shot_phase_ramp_tb: done, clean");
    end else begin
      $display("one_shot_phase_ramp_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/osp_pkg.sv
src/one_shot_phase_ramp.sv
src/osp_checker.sv
bench/osp_tb_pkg.sv
bench/osp_checker.sv
bench/one_shot_phase_ramp_tb.sv
